// File: rtl/shifting_array_table_top_defines.svh
// Assertion macros for the shifting array table.
// Taken in by the top level; the bodies drop out when SYNTHESIS is defined.
`ifndef SHIFTING_ARRAY_TABLE_TOP_DEFINES_SVH
`define SHIFTING_ARRAY_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAT_ASSERT_NOW(label, ante, cons, msg)
`define SAT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/sat_pkg.sv
// Shared codes and types for the shifting array table.
// No dependencies; used by sat_cell and the top level.
`default_nettype none

package sat_pkg;

    localparam int VALUE_W = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_REMOVE_AT  = 3'd2;
    localparam logic [2:0] CMD_REMOVE_VAL = 3'd3;
    localparam logic [2:0] CMD_FIND       = 3'd4;
    localparam logic [2:0] CMD_POP        = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // cell update codes
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_LOAD  = 2'd1;
    localparam logic [1:0] CELL_LEFT  = 2'd2;
    localparam logic [1:0] CELL_RIGHT = 2'd3;

    typedef struct packed {
        logic [1:0] op;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/sat_cell.sv
// One entry of the table: holds a value, shifts from either neighbor, compares.
// Depends on sat_pkg.
`default_nettype none

module sat_cell (
    input  wire logic                          clk,
    input  wire sat_pkg::cell_ctrl_t           ctrl,
    input  wire logic [sat_pkg::VALUE_W-1:0]   load_data,
    input  wire logic [sat_pkg::VALUE_W-1:0]   left_data,
    input  wire logic [sat_pkg::VALUE_W-1:0]   right_data,
    input  wire logic [sat_pkg::VALUE_W-1:0]   key,
    output logic      [sat_pkg::VALUE_W-1:0]   data,
    output logic                               match
);

    logic [sat_pkg::VALUE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            sat_pkg::CELL_LOAD:  data_reg <= load_data;
            sat_pkg::CELL_LEFT:  data_reg <= left_data;
            sat_pkg::CELL_RIGHT: data_reg <= right_data;
            default:             data_reg <= data_reg;
        endcase
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

`default_nettype wire

// File: rtl/sat_match_enc.sv
// Priority encoder over the cell match flags: lowest hit wins.
// Depends on nothing outside this file.
`default_nettype none

module sat_match_enc #(
    parameter int DEPTH = 16
) (
    input  wire logic [DEPTH-1:0]         hit,
    output logic                          any,
    output logic [$clog2(DEPTH)-1:0]      index
);

    localparam int IDX_W = $clog2(DEPTH);

    always_comb
    begin
        any   = |hit;
        index = '0;
        // scan downward so the lowest set flag is written last
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                index = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/shifting_array_table_top.sv
// Shifting array table: an ordered row of value cells with a fill count.
// Command channel: cmd/value/position under cmd_valid, cmd_stall.
// Result channel: found/found_index/value_out/fill_count/status under
// rsp_valid, rsp_stall. A transaction moves at a rising edge with valid high
// and stall low.
// Every command gives exactly one result, registered in the cycle after it is accepted.
// Throughput is one command per cycle while the receiver does not stall: all cells
// shift in the same edge and the compares run in every cell at once, feeding a priority encoder.
// The single result register sets the pace; a new command is taken in the
// same cycle the previous result leaves.
// When the receiver stalls, the result holds and cmd_stall rises until the
// result is taken. Reset empties the table (count zero) and drops rsp_valid;
// cell contents are not cleared and are only ever read below the count.
// Depends on sat_pkg, sat_cell, sat_match_enc and the defines header.
`default_nettype none
`include "shifting_array_table_top_defines.svh"

module shifting_array_table_top #(
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cmd_valid,
    output logic                                       cmd_stall,
    input  wire logic [2:0]                            cmd,
    input  wire logic signed [sat_pkg::VALUE_W-1:0]    value,
    input  wire logic [$clog2(DEPTH)-1:0]              position,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output logic                                       found,
    output logic [$clog2(DEPTH)-1:0]                   found_index,
    output logic signed [sat_pkg::VALUE_W-1:0]         value_out,
    output logic [$clog2(DEPTH+1)-1:0]                 fill_count,
    output logic [1:0]                                 status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         accept;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             res_count;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    logic                         found_reg;
    logic [IDX_W-1:0]             found_index_reg;
    logic [sat_pkg::VALUE_W-1:0]  value_out_reg;
    logic [CNT_W-1:0]             fill_count_reg;
    logic [1:0]                   status_reg;

    logic                         res_found;
    logic [IDX_W-1:0]             res_index;
    logic [sat_pkg::VALUE_W-1:0]  res_value;
    logic [1:0]                   res_status;

    logic                         do_append;
    logic                         do_front;
    logic                         do_remove;
    logic [IDX_W-1:0]             rm_idx;

    logic                         full;
    logic                         empty;
    logic [IDX_W-1:0]             last_idx;
    logic [CNT_W-1:0]             last_cnt;

    logic [sat_pkg::VALUE_W-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]             cell_match;
    logic [DEPTH-1:0]             hit;
    logic                         hit_any;
    logic [IDX_W-1:0]             hit_index;
    sat_pkg::cell_ctrl_t          cell_ctrl [DEPTH];

    assign cmd_stall = rsp_valid_reg & rsp_stall;
    assign accept    = cmd_valid & ~cmd_stall;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign last_cnt = count_reg - CNT_W'(1);
    assign last_idx = last_cnt[IDX_W-1:0];

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [sat_pkg::VALUE_W-1:0] left_d;
        logic [sat_pkg::VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].op = sat_pkg::CELL_HOLD;
            if (do_append && (CNT_W'(i) == count_reg))
            begin
                cell_ctrl[i].op = sat_pkg::CELL_LOAD;
            end
            else if (do_front)
            begin
                cell_ctrl[i].op = (i == 0) ? sat_pkg::CELL_LOAD : sat_pkg::CELL_LEFT;
            end
            else if (do_remove && (IDX_W'(i) >= rm_idx))
            begin
                cell_ctrl[i].op = sat_pkg::CELL_RIGHT;
            end
        end

        sat_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .load_data  (value),
            .left_data  (left_d),
            .right_data (right_d),
            .key        (value),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );

        // only cells below the count take part in a search
        assign hit[i] = cell_match[i] & (CNT_W'(i) < count_reg);
    end

    sat_match_enc #(
        .DEPTH (DEPTH)
    ) u_match_enc (
        .hit   (hit),
        .any   (hit_any),
        .index (hit_index)
    );

    // command decode
    always_comb
    begin
        res_found  = 1'b0;
        res_index  = '0;
        res_value  = '0;
        res_status = sat_pkg::ST_OK;
        res_count  = count_reg;
        do_append  = 1'b0;
        do_front   = 1'b0;
        do_remove  = 1'b0;
        rm_idx     = position;
        unique case (cmd) inside
            sat_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    res_status = sat_pkg::ST_FULL;
                end
                else
                begin
                    do_append = accept;
                    res_count = count_reg + CNT_W'(1);
                end
            end
            sat_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    res_status = sat_pkg::ST_FULL;
                end
                else
                begin
                    do_front  = accept;
                    res_count = count_reg + CNT_W'(1);
                end
            end
            sat_pkg::CMD_REMOVE_AT:
            begin
                if (CNT_W'(position) >= count_reg)
                begin
                    res_status = sat_pkg::ST_NONE;
                end
                else
                begin
                    do_remove = accept;
                    res_count = last_cnt;
                end
            end
            sat_pkg::CMD_REMOVE_VAL, sat_pkg::CMD_FIND:
            begin
                if (!hit_any)
                begin
                    res_status = sat_pkg::ST_NONE;
                end
                else
                begin
                    res_found = 1'b1;
                    res_index = hit_index;
                    if (cmd == sat_pkg::CMD_REMOVE_VAL)
                    begin
                        do_remove = accept;
                        rm_idx    = hit_index;
                        res_count = last_cnt;
                    end
                end
            end
            sat_pkg::CMD_POP:
            begin
                if (empty)
                begin
                    res_status = sat_pkg::ST_EMPTY;
                end
                else
                begin
                    res_value = cell_data[last_idx];
                    res_count = last_cnt;
                end
            end
            default:
            begin
                // unused codes: leave the table alone
            end
        endcase
    end

    assign count_next     = accept ? res_count : count_reg;
    assign rsp_valid_next = accept | (rsp_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result register: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg       <= res_found;
            found_index_reg <= res_index;
            value_out_reg   <= res_value;
            fill_count_reg  <= res_count;
            status_reg      <= res_status;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign value_out   = value_out_reg;
    assign fill_count  = fill_count_reg;
    assign status      = status_reg;

    `SAT_ASSERT_NOW(a_fill_bound, rsp_valid_reg, fill_count_reg <= CNT_W'(DEPTH), "fill count above depth")
    `SAT_ASSERT_NOW(a_full_status, rsp_valid_reg && (status_reg == sat_pkg::ST_FULL), fill_count_reg == CNT_W'(DEPTH), "full status with room left")
    `SAT_ASSERT_NOW(a_found_ok, rsp_valid_reg && found_reg, status_reg == sat_pkg::ST_OK, "match reported with error status")
    `SAT_ASSERT_NEXT(a_count_hold, !accept, count_reg == $past(count_reg), "count moved without a command")

endmodule

`default_nettype wire
